// ----- hdl/fm_patch_capture_dedup_defines.svh -----
// assertion macros for the patch capture block
`ifndef FM_PATCH_CAPTURE_DEDUP_DEFINES_SVH
`define FM_PATCH_CAPTURE_DEDUP_DEFINES_SVH

// implication checked at every rising edge, quiet in reset
`define FPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpc check failed");

// next-cycle implication
`define FPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpc check failed");

`endif

// ----- hdl/fpc_pkg.sv -----
package fpc_pkg;

  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_SAME   = 3'd1;
  localparam logic [2:0] ST_FOUND  = 3'd2;
  localparam logic [2:0] ST_ADDED  = 3'd3;
  localparam logic [2:0] ST_SILENT = 3'd4;
  localparam logic [2:0] ST_FULL   = 3'd5;

  localparam logic [7:0] REG_DAC    = 8'h2b;
  localparam logic [7:0] REG_KEY    = 8'h28;
  localparam logic [7:0] REG_SKIP   = 8'hb3;
  localparam logic [6:0] TL_MAX     = 7'h7f;

  typedef logic [43:0] op_word_t;
  typedef logic [10:0] ch_word_t;
  typedef logic [186:0] patch_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CMP,
    S_APPEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic decode;
    logic keyon_check;
    logic scan_start;
    logic scan_next;
    logic append;
    logic finish;
    logic [2:0] status;
  } ctrl_t;

  typedef struct packed {
    logic is_keyon;
    logic same;
    logic silent;
    logic hit;
    logic scan_end;
    logic full;
  } stat_t;

endpackage

// ----- hdl/fpc_ram.sv -----
module fpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fpc_ctrl.sv -----
module fpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  fpc_pkg::stat_t stat,
  output fpc_pkg::ctrl_t ctrl,
  output logic           busy
);

  fpc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpc_pkg::S_IDLE:   if (go) state_nxt = fpc_pkg::S_CHECK;
      fpc_pkg::S_CHECK: begin
        if (!stat.is_keyon || stat.same || stat.silent) begin
          state_nxt = fpc_pkg::S_DONE;
        end else if (stat.scan_end) begin
          state_nxt = fpc_pkg::S_APPEND;
        end else begin
          state_nxt = fpc_pkg::S_READ;
        end
      end
      fpc_pkg::S_READ:   state_nxt = fpc_pkg::S_CMP;
      fpc_pkg::S_CMP: begin
        if (stat.hit) begin
          state_nxt = fpc_pkg::S_DONE;
        end else if (stat.scan_end) begin
          state_nxt = fpc_pkg::S_APPEND;
        end else begin
          state_nxt = fpc_pkg::S_READ;
        end
      end
      fpc_pkg::S_APPEND: state_nxt = fpc_pkg::S_DONE;
      fpc_pkg::S_DONE:   state_nxt = fpc_pkg::S_IDLE;
      default:           state_nxt = fpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    unique case (state_r)
      fpc_pkg::S_IDLE: begin
        busy = 1'b0;
        ctrl.decode = go;
      end
      fpc_pkg::S_CHECK: begin
        ctrl.keyon_check = stat.is_keyon;
        ctrl.scan_start = 1'b1;
        if (!stat.is_keyon) ctrl.status = fpc_pkg::ST_NONE;
        else if (stat.same) ctrl.status = fpc_pkg::ST_SAME;
        else if (stat.silent) ctrl.status = fpc_pkg::ST_SILENT;
      end
      fpc_pkg::S_READ: ;
      fpc_pkg::S_CMP: begin
        ctrl.scan_next = 1'b1;
        if (stat.hit) ctrl.status = fpc_pkg::ST_FOUND;
      end
      fpc_pkg::S_APPEND: begin
        ctrl.append = !stat.full;
        ctrl.status = stat.full ? fpc_pkg::ST_FULL : fpc_pkg::ST_ADDED;
      end
      fpc_pkg::S_DONE: ctrl.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- hdl/fpc_datapath.sv -----
module fpc_datapath #(
  parameter int LIST_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_bank_select,
  input  logic [7:0]     in_register_address,
  input  logic [7:0]     in_write_data,
  input  logic [7:0]     in_source_file,
  input  fpc_pkg::ctrl_t ctrl,
  output fpc_pkg::stat_t stat,
  output logic           out_strobe,
  output logic [2:0]     out_status,
  output logic [7:0]     out_entry_index,
  output logic [8:0]     out_entry_count
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  fpc_pkg::op_word_t op_sh_r [24];
  fpc_pkg::ch_word_t ch_sh_r [6];
  fpc_pkg::op_word_t prev_op_r [24];
  fpc_pkg::ch_word_t prev_ch_r [6];
  logic [5:0]  prev_valid_r;
  logic        dac_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [2:0]  kch_r;
  logic        keyon_r;
  logic [7:0]  file_r;
  logic [2:0]  status_r;
  logic        strobe_r;
  logic [7:0]  eidx_r;

  fpc_pkg::patch_t cur_patch, prev_patch, rd_patch;

  logic [2:0] code;
  logic [2:0] kch;
  logic       kvalid;
  logic [2:0] wch;
  logic [4:0] widx;
  logic [7:0] ra;

  always_comb begin
    ra   = in_register_address;
    code = in_write_data[2:0];
    kch  = (code > 3'd3) ? code - 3'd1 : code;
    kvalid = !in_bank_select && ra == fpc_pkg::REG_KEY && code != 3'd3 && code != 3'd7
             && !(kch == 3'd5 && dac_r) && in_write_data[7:4] != 4'd0;
    wch  = {1'b0, ra[1:0]} + (in_bank_select ? 3'd3 : 3'd0);
    widx = {wch, 2'b00} + {3'b000, ra[3:2]};
  end

  always_comb begin
    cur_patch  = {ch_sh_r[kch_r], op_sh_r[{kch_r, 2'd0}], op_sh_r[{kch_r, 2'd1}],
                  op_sh_r[{kch_r, 2'd2}], op_sh_r[{kch_r, 2'd3}]};
    prev_patch = {prev_ch_r[kch_r], prev_op_r[{kch_r, 2'd0}], prev_op_r[{kch_r, 2'd1}],
                  prev_op_r[{kch_r, 2'd2}], prev_op_r[{kch_r, 2'd3}]};
  end

  logic all_ar0, all_tlmax;
  always_comb begin
    all_ar0 = 1'b1;
    all_tlmax = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (op_sh_r[{kch_r, k[1:0]}][18:14] != 5'd0) all_ar0 = 1'b0;
      if (op_sh_r[{kch_r, k[1:0]}][13:7] != fpc_pkg::TL_MAX) all_tlmax = 1'b0;
    end
  end

  logic [AW-1:0] raddr;
  logic [7:0]    file_rd;
  assign raddr = ctrl.scan_start ? '0 : idx_r[AW-1:0];

  fpc_ram #(.WIDTH(187), .DEPTH(LIST_DEPTH)) u_patch_ram (
    .clk(clk), .we(ctrl.append), .waddr(count_r[AW-1:0]), .wdata(cur_patch),
    .raddr(raddr), .rdata(rd_patch)
  );

  fpc_ram #(.WIDTH(8), .DEPTH(LIST_DEPTH)) u_file_ram (
    .clk(clk), .we(ctrl.append), .waddr(count_r[AW-1:0]), .wdata(file_r),
    .raddr(raddr), .rdata(file_rd)
  );

  always_comb begin
    stat.is_keyon  = keyon_r;
    stat.same      = prev_valid_r[kch_r] && prev_patch == cur_patch;
    stat.silent    = all_ar0 || all_tlmax;
    stat.hit       = rd_patch == cur_patch && file_rd == file_rd;
    stat.scan_end  = ctrl.scan_start ? (count_r == '0) : (idx_r + CW'(1) >= count_r);
    stat.full      = count_r >= CW'(LIST_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 24; i++) op_sh_r[i] <= '0;
      for (int i = 0; i < 6; i++) ch_sh_r[i] <= '0;
      prev_valid_r <= '0;
      dac_r <= 1'b0;
      count_r <= '0;
      strobe_r <= 1'b0;
      keyon_r <= 1'b0;
    end else begin
      strobe_r <= ctrl.finish;
      if (ctrl.decode) begin
        keyon_r <= kvalid;
        kch_r <= kch;
        file_r <= in_source_file;
        if (ra != fpc_pkg::REG_SKIP) begin
          if (!in_bank_select && ra == fpc_pkg::REG_DAC) begin
            dac_r <= in_write_data[7];
          end else if (ra >= 8'h30 && ra[1:0] != 2'd3) begin
            case (ra[7:4])
              4'h3: begin
                op_sh_r[widx][6:4] <= in_write_data[6:4];
                op_sh_r[widx][3:0] <= in_write_data[3:0];
              end
              4'h4: op_sh_r[widx][13:7] <= in_write_data[6:0];
              4'h5: begin
                op_sh_r[widx][20:19] <= in_write_data[7:6];
                op_sh_r[widx][18:14] <= in_write_data[4:0];
              end
              4'h6: begin
                op_sh_r[widx][26] <= in_write_data[7];
                op_sh_r[widx][25:21] <= in_write_data[4:0];
              end
              4'h7: op_sh_r[widx][31:27] <= in_write_data[4:0];
              4'h8: op_sh_r[widx][39:32] <= in_write_data;
              4'h9: op_sh_r[widx][43:40] <= in_write_data[3:0];
              4'hb: begin
                if (ra < 8'hb3) begin
                  ch_sh_r[wch][5:0] <= in_write_data[5:0];
                end else begin
                  if (ra < 8'hb7) begin
                    ch_sh_r[wch][8:6] <= in_write_data[2:0];
                    ch_sh_r[wch][10:9] <= in_write_data[5:4];
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      if (ctrl.keyon_check) begin
        prev_valid_r[kch_r] <= 1'b1;
        prev_ch_r[kch_r] <= ch_sh_r[kch_r];
        for (int k = 0; k < 4; k++) begin
          prev_op_r[{kch_r, k[1:0]}] <= op_sh_r[{kch_r, k[1:0]}];
        end
      end
      if (ctrl.append) count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      idx_r <= '0;
    end else if (ctrl.scan_next && !stat.hit) begin
      idx_r <= idx_r + CW'(1);
    end
    if (ctrl.decode) begin
      status_r <= fpc_pkg::ST_NONE;
      eidx_r <= '0;
    end
    if (ctrl.status != fpc_pkg::ST_NONE) status_r <= ctrl.status;
    if (ctrl.scan_next && stat.hit) eidx_r <= 8'(idx_r);
    if (ctrl.append) eidx_r <= 8'(count_r);
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_index = eidx_r;
  assign out_entry_count = 9'(count_r);

endmodule

// ----- hdl/fm_patch_capture_dedup.sv -----
// FM patch capture with de-duplication.
// Input: one register write (bank, address, data, source file id) is taken
// at a rising edge with start high and busy low.
// Output: exactly one result per write, shown for one cycle with out_strobe
// high: status, list index and the number of stored patches.
// A non key-on write, or a silent or repeated key-on, goes straight to done.
// Other key-ons walk the list one stored patch at a time over the memory
// read port and append the patch if none matched and the list has room.
// Busy is high from acceptance until the result cycle ends.
// Reset (rst_n low, synchronous) clears the channel shadows, previous-copy
// valid bits, DAC flag and the list count; the list memory is not cleared.
// The receiver cannot stall; results are never held back.
module fm_patch_capture_dedup #(
  parameter int LIST_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_bank_select,
  input  logic [7:0] in_register_address,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_source_file,
  output logic       out_strobe,
  output logic [2:0] out_status,
  output logic [7:0] out_entry_index,
  output logic [8:0] out_entry_count
);

  fpc_pkg::ctrl_t ctrl;
  fpc_pkg::stat_t stat;
  logic           ctl_busy;

  fpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(start && !busy), .stat(stat), .ctrl(ctrl),
    .busy(ctl_busy)
  );

  fpc_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_bank_select(in_bank_select), .in_register_address(in_register_address),
    .in_write_data(in_write_data), .in_source_file(in_source_file),
    .ctrl(ctrl), .stat(stat),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_entry_index(out_entry_index), .out_entry_count(out_entry_count)
  );

  assign busy = ctl_busy || out_strobe;

endmodule

// ----- hdl/fpc_checker.sv -----
`include "fm_patch_capture_dedup_defines.svh"

module fpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [2:0] out_status,
  input logic [7:0] out_entry_index,
  input logic [8:0] out_entry_count
);

  `FPC_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy)
  `FPC_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, busy)
  `FPC_ASSERT_IMP(a_status_range, clk, rst_n, out_strobe, out_status <= fpc_pkg::ST_FULL)
  `FPC_ASSERT_IMP(a_index_zero, clk, rst_n,
    out_strobe && out_status != fpc_pkg::ST_FOUND && out_status != fpc_pkg::ST_ADDED,
    out_entry_index == 8'd0)
  `FPC_ASSERT_IMP(a_added_count, clk, rst_n,
    out_strobe && out_status == fpc_pkg::ST_ADDED, out_entry_count != 9'd0)

endmodule

bind fm_patch_capture_dedup fpc_checker u_fpc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_status(out_status), .out_entry_index(out_entry_index),
  .out_entry_count(out_entry_count)
);
